// File: sv/kcrs_pkg.sv
// shared types and codes for the keyed command radix sorter
`timescale 1ns / 1ps
package kcrs_pkg;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_OOR  = 2'd2;

    localparam int KEY_BITS = 64;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key;
        logic [31:0] payload;
        logic [9:0]  index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] count;
        logic [63:0] key_out;
        logic [31:0] payload_out;
    } rsp_t;

endpackage

// File: sv/keyed_command_radix_sorter.sv
// top level of the keyed command radix sorter
`timescale 1ns / 1ps
// usage: one command channel (start/busy, cmd) and one result channel (done, rsp).
// a command beat is taken when start is high and busy is low; every command
// gives exactly one result beat, shown with done for one cycle. the receiver
// cannot stall.
// push and clear go through the response state to the registered result; read
// first waits in S_RD for the registered ram read, then loads the output register.
// flush runs a least-significant-digit radix sort: for each digit pass it
// clears all 2^DIGIT_BITS buckets of the histogram ram, counts the entries
// (read-modify-write on the histogram ram), turns counts into offsets,
// scatters, copies scratch back and steps to the next digit. the number of
// passes is ceil(64/DIGIT_BITS).
// busy is high while any command is in flight, so commands are processed one
// at a time. reset empties the store; ram contents are left undefined.
module keyed_command_radix_sorter #(
    parameter int CAPACITY      = 1024,
    parameter int PAYLOAD_WIDTH = 32,
    parameter int DIGIT_BITS    = 11
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  kcrs_pkg::cmd_t cmd,
    output logic           done,
    output kcrs_pkg::rsp_t rsp
);
    import kcrs_pkg::*;

    localparam int AW      = $clog2(CAPACITY);
    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int BUCKETS = 1 << DIGIT_BITS;
    localparam int HW      = DIGIT_BITS;
    localparam int PASSES  = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PW      = $clog2(PASSES + 1);
    localparam int SHW     = 7;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_RSP    = 4'd2;
    localparam logic [3:0] S_HCLR   = 4'd3;
    localparam logic [3:0] S_CNT_A  = 4'd4;
    localparam logic [3:0] S_CNT_B  = 4'd5;
    localparam logic [3:0] S_CNT_C  = 4'd6;
    localparam logic [3:0] S_PRE_A  = 4'd7;
    localparam logic [3:0] S_PRE_B  = 4'd8;
    localparam logic [3:0] S_SCT_A  = 4'd9;
    localparam logic [3:0] S_SCT_B  = 4'd10;
    localparam logic [3:0] S_SCT_C  = 4'd11;
    localparam logic [3:0] S_CPY    = 4'd12;
    localparam logic [3:0] S_PASS   = 4'd13;

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [HW:0]        b_reg, b_next;
    logic [PW-1:0]      pass_reg, pass_next;
    logic [SHW-1:0]     shift_reg, shift_next;
    logic [CW-1:0]      offs_reg, offs_next;
    logic [1:0]         status_reg, status_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;
    logic [HW-1:0]      dig_reg, dig_next;

    // store rams
    logic                     ks_we, ps_we;
    logic [AW-1:0]            ks_wa, ks_ra;
    logic [63:0]              ks_wd, ks_rd;
    logic [PAYLOAD_WIDTH-1:0] ps_wd, ps_rd;
    // scratch rams
    logic                     sc_we;
    logic [AW-1:0]            sc_wa, sc_ra;
    logic [63:0]              sk_rd;
    logic [PAYLOAD_WIDTH-1:0] sp_rd;
    // histogram ram
    logic                     h_we;
    logic [HW-1:0]            h_wa, h_ra;
    logic [CW-1:0]            h_wd, h_rd;

    kcrs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_key_store (
        .clk(clk), .we(ks_we), .waddr(ks_wa), .wdata(ks_wd), .raddr(ks_ra), .rdata(ks_rd));
    kcrs_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(CAPACITY)) u_pay_store (
        .clk(clk), .we(ps_we), .waddr(ks_wa), .wdata(ps_wd), .raddr(ks_ra), .rdata(ps_rd));
    kcrs_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_key_scratch (
        .clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(ks_rd), .raddr(sc_ra), .rdata(sk_rd));
    kcrs_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(CAPACITY)) u_pay_scratch (
        .clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(ps_rd), .raddr(sc_ra), .rdata(sp_rd));
    kcrs_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_hist (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));

    logic [63:0]   shifted;
    logic [HW-1:0] cur_dig;

    assign shifted = ks_rd >> shift_reg;
    assign cur_dig = shifted[HW-1:0];

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        b_next      = b_reg;
        pass_next   = pass_reg;
        shift_next  = shift_reg;
        offs_next   = offs_reg;
        status_next = status_reg;
        rd_ok_next  = rd_ok_reg;
        dig_next    = dig_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        ks_we = 1'b0;
        ps_we = 1'b0;
        ks_wa = count_reg[AW-1:0];
        ks_wd = cmd.key;
        ps_wd = cmd.payload[PAYLOAD_WIDTH-1:0];
        ks_ra = i_reg[AW-1:0];
        sc_we = 1'b0;
        sc_wa = h_rd[AW-1:0];
        sc_ra = i_reg[AW-1:0];
        h_we  = 1'b0;
        h_wa  = b_reg[HW-1:0];
        h_wd  = '0;
        h_ra  = b_reg[HW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = ST_OK;
                    rd_ok_next  = 1'b0;
                    unique case (cmd.operation)
                        OP_PUSH:
                        begin
                            if (count_reg < CW'(CAPACITY))
                            begin
                                ks_we = 1'b1;
                                ps_we = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                            state_next = S_RSP;
                        end
                        OP_FLUSH:
                        begin
                            pass_next  = '0;
                            shift_next = '0;
                            b_next     = '0;
                            state_next = (count_reg == '0) ? S_RSP : S_HCLR;
                        end
                        OP_READ:
                        begin
                            // keep the read address on the store until the result is taken
                            ks_ra  = cmd.index[AW-1:0];
                            i_next = CW'(cmd.index);
                            if (CW'(cmd.index) < count_reg)
                            begin
                                rd_ok_next = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_OOR;
                            end
                            state_next = S_RD;
                        end
                        default:
                        begin
                            count_next = '0;
                            state_next = S_RSP;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_RSP;
            end
            S_RSP:
            begin
                done_next = 1'b1;
                rsp_next.status      = status_reg;
                rsp_next.count       = 11'(count_reg);
                rsp_next.key_out     = rd_ok_reg ? ks_rd : 64'd0;
                rsp_next.payload_out = rd_ok_reg ? 32'(ps_rd) : 32'd0;
                state_next = S_IDLE;
            end
            S_HCLR:
            begin
                h_we = 1'b1;
                b_next = b_reg + 1'b1;
                if (b_reg == (HW+1)'(BUCKETS - 1))
                begin
                    i_next = '0;
                    state_next = S_CNT_A;
                end
            end
            // count: read key, read bucket, write bucket+1
            S_CNT_A:
            begin
                state_next = S_CNT_B;
            end
            S_CNT_B:
            begin
                h_ra = cur_dig;
                dig_next = cur_dig;
                state_next = S_CNT_C;
            end
            S_CNT_C:
            begin
                h_we = 1'b1;
                h_wa = dig_reg;
                h_wd = h_rd + 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 == count_reg)
                begin
                    b_next = '0;
                    offs_next = '0;
                    state_next = S_PRE_A;
                end
                else
                begin
                    state_next = S_CNT_A;
                end
            end
            // exclusive prefix sum over the buckets
            S_PRE_A:
            begin
                state_next = S_PRE_B;
            end
            S_PRE_B:
            begin
                h_we = 1'b1;
                h_wd = offs_reg;
                offs_next = offs_reg + h_rd;
                b_next = b_reg + 1'b1;
                if (b_reg == (HW+1)'(BUCKETS - 1))
                begin
                    i_next = '0;
                    state_next = S_SCT_A;
                end
                else
                begin
                    state_next = S_PRE_A;
                end
            end
            S_SCT_A:
            begin
                state_next = S_SCT_B;
            end
            S_SCT_B:
            begin
                h_ra = cur_dig;
                dig_next = cur_dig;
                state_next = S_SCT_C;
            end
            // store read data is still held since the store ram read address is unchanged
            S_SCT_C:
            begin
                sc_we = 1'b1;
                h_we = 1'b1;
                h_wa = dig_reg;
                h_wd = h_rd + 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 == count_reg)
                begin
                    i_next = '0;
                    state_next = S_CPY;
                end
                else
                begin
                    state_next = S_SCT_A;
                end
            end
            // copy back: scratch read at i, write store at i-1
            S_CPY:
            begin
                if (i_reg != '0)
                begin
                    ks_we = 1'b1;
                    ps_we = 1'b1;
                    ks_wa = AW'(i_reg - 1'b1);
                    ks_wd = sk_rd;
                    ps_wd = sp_rd;
                end
                i_next = i_reg + 1'b1;
                if (i_reg == count_reg)
                begin
                    state_next = S_PASS;
                end
            end
            S_PASS:
            begin
                pass_next  = pass_reg + 1'b1;
                shift_next = shift_reg + SHW'(DIGIT_BITS);
                b_next     = '0;
                i_next     = '0;
                state_next = (pass_reg == PW'(PASSES - 1)) ? S_RSP : S_HCLR;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            i_reg      <= '0;
            b_reg      <= '0;
            pass_reg   <= '0;
            shift_reg  <= '0;
            rd_ok_reg  <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            i_reg      <= i_next;
            b_reg      <= b_next;
            pass_reg   <= pass_next;
            shift_reg  <= shift_next;
            rd_ok_reg  <= rd_ok_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offs_reg <= offs_next;
        dig_reg  <= dig_next;
        rsp_reg  <= rsp_next;
    end
endmodule

// File: sv/kcrs_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module kcrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
